// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; take it with a bare include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: check always");

// antecedent in this cycle implies consequent in the next one
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: check next");

`endif

// File: sv/mpk_pkg.sv
// types and constants for the max profit k trades block
// no dependencies
`timescale 1ns / 1ps

package mpk_pkg;

    localparam int PRICE_W       = 16;
    localparam int HOLD_W        = 34;
    localparam int FLAT_W        = 33;
    localparam int PROFIT_W      = 32;
    localparam int TRADES_W      = 5;
    localparam int DEFAULT_LIMIT = 16;

    localparam logic [TRADES_W-1:0] MAX_TRADES_RESET = 5'd1;

    // no unit held yet
    localparam logic signed [HOLD_W-1:0] HOLD_EMPTY = {1'b1, {(HOLD_W-1){1'b0}}};

    // register addresses (byte address bit 2 selects the register)
    localparam logic REG_MAX_TRADES = 1'b0;

    // what one cell hands its neighbor each cycle
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [PRICE_W-1:0]         price;
        logic signed [FLAT_W-1:0]   flat;  // flat value of the cell before, ahead of this price
        logic signed [FLAT_W-1:0]   best;  // running best profit toward the output
    } mpk_link_t;

endpackage

// File: sv/max_profit_k_trades_unit.sv
// best profit with at most k buy-sell pairs over a price stream
// depends on mpk_pkg, mpk_cell, mpk_out_stage and assert_macros.svh
//
// usage:
//   s_t* carries prices (tdata = price, tlast = last price of a sequence).
//   m_t* carries one result per sequence (tdata = best profit, 32 bits).
//   apb register 0 (byte address 0) is max_trades, 5 bits, reset 1.
// the block is a chain of MAX_TRADES_LIMIT cells, one per trade count;
// each price walks down the chain one cell per cycle unless it is held,
// with the flat value of the cell before it, so a new price is taken
// every cycle unless the chain is held. the last price of a sequence
// passes every cell register and the output register before m_tvalid rises.
// throughput: one price per cycle while the chain is not held.
// reset clears every cell to the empty state and max_trades to 1; each
// cell clears itself again as the last price of a sequence passes it.
// when the receiver stalls, the result waits in the output register and
// prices keep flowing; the chain stops only when a second result reaches
// the tail while the first is still waiting.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module max_profit_k_trades_unit #(
    parameter int MAX_TRADES_LIMIT = mpk_pkg::DEFAULT_LIMIT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] price
    input  logic                          s_tlast,   // last_price
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] best_profit
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [mpk_pkg::TRADES_W-1:0] max_trades_reg, max_trades_next;
    logic                         advance;
    mpk_pkg::mpk_link_t           link [MAX_TRADES_LIMIT+1];

    // configuration register
    always_comb
    begin
        max_trades_next = max_trades_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == mpk_pkg::REG_MAX_TRADES))
        begin
            max_trades_next = pwdata[mpk_pkg::TRADES_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == mpk_pkg::REG_MAX_TRADES)
        begin
            prdata = {{(32-mpk_pkg::TRADES_W){1'b0}}, max_trades_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_trades_reg <= mpk_pkg::MAX_TRADES_RESET;
        end
        else
        begin
            max_trades_reg <= max_trades_next;
        end
    end

    assign pready = 1'b1;

    // head of the chain: trade count zero buys out of zero cash
    always_comb
    begin
        link[0].valid = s_tvalid;
        link[0].last  = s_tlast;
        link[0].price = s_tdata;
        link[0].flat  = '0;
        link[0].best  = '0;
    end

    assign s_tready = advance;

    for (genvar g = 0; g < MAX_TRADES_LIMIT; g++)
    begin : g_cell
        mpk_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .max_trades (max_trades_reg),
            .link_in    (link[g]),
            .link_out   (link[g+1])
        );
    end

    mpk_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .tail     (link[MAX_TRADES_LIMIT]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .advance  (advance)
    );

    `ASSERT_ALWAYS(a_zero_trades_zero_profit, clk, rst_n,
        !(link[MAX_TRADES_LIMIT].valid && link[MAX_TRADES_LIMIT].last &&
          max_trades_reg == '0) || link[MAX_TRADES_LIMIT].best == '0)
    `ASSERT_NEXT(a_result_lands, clk, rst_n,
        advance && link[MAX_TRADES_LIMIT].valid && link[MAX_TRADES_LIMIT].last,
        m_tvalid)

endmodule

// File: sv/mpk_cell.sv
// one trade count of the chain: holding and flat best for count IDX
// depends on mpk_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpk_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [mpk_pkg::TRADES_W-1:0]       max_trades,
    input  mpk_pkg::mpk_link_t                 link_in,
    output mpk_pkg::mpk_link_t                 link_out
);

    localparam logic [6:0] IDX_C = 7'(IDX);

    logic signed [mpk_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic signed [mpk_pkg::FLAT_W-1:0] flat_reg, flat_next;
    mpk_pkg::mpk_link_t                link_reg, link_next;

    logic signed [mpk_pkg::HOLD_W-1:0] price_s;
    logic signed [mpk_pkg::HOLD_W-1:0] prev_flat_s;
    logic signed [mpk_pkg::HOLD_W-1:0] flat_s;
    logic signed [mpk_pkg::HOLD_W-1:0] sell;
    logic signed [mpk_pkg::HOLD_W-1:0] buy;
    logic signed [mpk_pkg::HOLD_W-1:0] hold_upd;
    logic signed [mpk_pkg::FLAT_W-1:0] flat_upd;
    logic                              counts;

    always_comb
    begin
        price_s     = {{(mpk_pkg::HOLD_W-mpk_pkg::PRICE_W){1'b0}}, link_in.price};
        prev_flat_s = {link_in.flat[mpk_pkg::FLAT_W-1], link_in.flat};
        flat_s      = {flat_reg[mpk_pkg::FLAT_W-1], flat_reg};
        sell        = hold_reg + price_s;
        buy         = prev_flat_s - price_s;
        hold_upd    = (buy > hold_reg) ? buy : hold_reg;
        // a winning sell is never negative, so it fits the flat width
        flat_upd    = (sell > flat_s) ? sell[mpk_pkg::FLAT_W-1:0] : flat_reg;
        counts      = {2'b00, max_trades} > IDX_C;

        hold_next = hold_reg;
        flat_next = flat_reg;
        link_next = link_reg;
        if (advance)
        begin
            link_next.valid = link_in.valid;
            if (link_in.valid)
            begin
                link_next.last  = link_in.last;
                link_next.price = link_in.price;
                link_next.flat  = flat_reg;
                link_next.best  = link_in.best;
                if (link_in.last)
                begin
                    // sequence ends here: fold into the result and start over
                    if (counts && (flat_upd > link_in.best))
                    begin
                        link_next.best = flat_upd;
                    end
                    hold_next = mpk_pkg::HOLD_EMPTY;
                    flat_next = '0;
                end
                else
                begin
                    hold_next = hold_upd;
                    flat_next = flat_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= mpk_pkg::HOLD_EMPTY;
            flat_reg <= '0;
            link_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
            flat_reg <= flat_next;
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

    `ASSERT_ALWAYS(a_flat_nonneg, clk, rst_n, !flat_reg[mpk_pkg::FLAT_W-1])
    `ASSERT_NEXT(a_clear_after_last, clk, rst_n,
        advance && link_in.valid && link_in.last,
        hold_reg == mpk_pkg::HOLD_EMPTY && flat_reg == '0)

endmodule

// File: sv/mpk_out_stage.sv
// output register at the tail of the chain, with the chain advance control
// depends on mpk_pkg
`timescale 1ns / 1ps

module mpk_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mpk_pkg::mpk_link_t              tail,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [mpk_pkg::PROFIT_W-1:0]    m_tdata,
    output logic                            advance
);

    logic                          out_valid_reg, out_valid_next;
    logic [mpk_pkg::PROFIT_W-1:0]  out_data_reg, out_data_next;
    logic                          tail_result;

    always_comb
    begin
        tail_result = tail.valid && tail.last;
        // hold the chain only when a result would land on an occupied register
        advance     = !(tail_result && out_valid_reg && !m_tready);

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && tail_result)
        begin
            out_valid_next = 1'b1;
            // best is nonnegative in a 33-bit signed word, so 32 bits hold it
            out_data_next  = tail.best[mpk_pkg::PROFIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
